// File: rtl/core/mwpo_pkg.sv
// Shared constants and the fixed-point sine routine for the multi-waveform oscillator.
// No dependencies; used by mwpo_sine_rom, multi_waveform_phase_oscillator and the testbench.
`timescale 1ns / 1ps

package mwpo_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLUME_GAIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVE_SELECT = 2'd2;

    // waveform select codes
    localparam int WAVE_BITS = 3;
    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd3;
    localparam logic [WAVE_BITS-1:0] WAVE_INV_SAW  = 3'd4;

    localparam int PHASE_INC_BITS = 32;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 32;

    // sine series constants (Q30 fixed point)
    localparam int MAG_MAX_BITS = 24;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam int SERIES_TERMS = 5;
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // Magnitude of sin(pi/2 * u / 2^30) scaled by fs_m1, rounded half up.
    // Elaboration-time only: builds the quarter-wave table.
    function automatic logic [MAG_MAX_BITS-1:0] sine_mag(input logic [30:0] u,
                                                         input logic [MAG_MAX_BITS-1:0] fs_m1);
        logic [63:0] theta;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] mag;
        theta = ({33'b0, u} * PI_Q30) >> 31;
        sq    = (theta * theta) >> 30;
        acc   = ONE_Q30;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            acc = ONE_Q30 - (((sq * acc) >> 30) / SERIES_DIV[k]);
        end
        s = (theta * acc) >> 30;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        mag = (s * {40'b0, fs_m1} + (ONE_Q30 >> 1)) >> 30;
        return mag[MAG_MAX_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/mwpo_sine_rom.sv
// Quarter-wave sine magnitude ROM with registered read.
// Depends on mwpo_pkg (sine_mag routine).
`timescale 1ns / 1ps

module mwpo_sine_rom #(
    parameter int ADDR_BITS = 9,   // quarter depth is 2**(ADDR_BITS-1), plus the peak entry
    parameter int MAG_BITS  = 15
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic [MAG_BITS-1:0]  o_mag
);

    localparam int QTR_DEPTH = 2 ** (ADDR_BITS - 1);

    typedef logic [MAG_BITS-1:0] t_rom [0:QTR_DEPTH];

    function automatic t_rom build_rom();
        t_rom                                rom;
        logic [mwpo_pkg::MAG_MAX_BITS-1:0]   fs_m1;
        logic [mwpo_pkg::MAG_MAX_BITS-1:0]   mag;
        logic [30:0]                         u;
        fs_m1 = mwpo_pkg::MAG_MAX_BITS'((64'd1 << MAG_BITS) - 64'd1);
        for (int k = 0; k <= QTR_DEPTH; k++) begin
            u      = 31'(64'(k) << (30 - (ADDR_BITS - 1)));
            mag    = mwpo_pkg::sine_mag(u, fs_m1);
            rom[k] = mag[MAG_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [MAG_BITS-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= SINE_ROM[i_addr];
        end
    end

    assign o_mag = r_mag;

endmodule

// File: rtl/core/multi_waveform_phase_oscillator.sv
// Multi-waveform DDS oscillator top level: phase accumulator, waveform generation, gain.
// Depends on mwpo_pkg and mwpo_sine_rom.
`timescale 1ns / 1ps

// Each input transfer is one tick: the 32-bit-style phase accumulator (PHASE_BITS wide) is
// optionally cleared by restart, then advanced by phase_increment, and the new phase yields
// one sample of the selected waveform (sine, square, triangle, saw, inverse saw) multiplied
// by the Q0.16 volume gain and saturated to signed Q1.15 (SAMPLE_BITS in general). Exactly
// one output transfer follows each input transfer. Throughput is one tick per clock while
// the output is not stalled; there are three register stages (phase register, waveform/ROM
// register, gain multiply into the output register). Only the phase add feeds back on itself.
// Sine comes from a quarter-wave ROM of TABLE_DEPTH/4+1 entries built at elaboration, so the
// ROM needs no fill time after reset. TABLE_DEPTH must be a power of two. Write configuration
// only while no tick is in flight; unknown waveform codes give zero samples.

module multi_waveform_phase_oscillator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,

    // configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,

    // tick stream in
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [7:0]                               s_axis_tdata,  // [0] restart, rest zero

    // sample stream out
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata   // [SAMPLE_BITS-1:0] sample
);

    localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TBL_BITS       = $clog2(TABLE_DEPTH);
    localparam int QTR_ADDR_BITS  = TBL_BITS - 1;
    localparam int QTR_DEPTH      = TABLE_DEPTH / 4;
    localparam int MAG_BITS       = SAMPLE_BITS - 1;
    localparam int W_BITS         = SAMPLE_BITS + 1;   // waveform value, [-FS, FS]
    localparam int X_BITS         = SAMPLE_BITS + 2;   // headroom for waveform math
    localparam int GS_BITS        = mwpo_pkg::GAIN_BITS + 1;
    localparam int P_BITS         = W_BITS + GS_BITS;

    localparam logic signed [X_BITS-1:0] FS_X   = X_BITS'(2 ** (SAMPLE_BITS - 1));
    localparam logic signed [X_BITS-1:0] FS3_X  = X_BITS'(3 * (2 ** (SAMPLE_BITS - 1)));
    localparam logic signed [X_BITS-1:0] SAT_HI = X_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [X_BITS-1:0] SAT_LO = X_BITS'(-(2 ** (SAMPLE_BITS - 1)));

    // ---------------- configuration registers ----------------
    logic [mwpo_pkg::PHASE_INC_BITS-1:0] r_phase_inc;
    logic [mwpo_pkg::GAIN_BITS-1:0]      r_gain;
    logic [mwpo_pkg::WAVE_BITS-1:0]      r_wsel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_gain      <= '0;
            r_wsel      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mwpo_pkg::CFG_PHASE_INC:   r_phase_inc <= i_cfg_data;
                mwpo_pkg::CFG_VOLUME_GAIN: r_gain      <= i_cfg_data[mwpo_pkg::GAIN_BITS-1:0];
                mwpo_pkg::CFG_WAVE_SELECT: r_wsel      <= i_cfg_data[mwpo_pkg::WAVE_BITS-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r_va, r_vb, r_vc;
    logic rdy_a, rdy_b, rdy_c;
    logic acc_a, mv_b, mv_c;

    assign rdy_c = !r_vc || m_axis_tready;
    assign rdy_b = !r_vb || rdy_c;
    assign rdy_a = !r_va || rdy_b;
    assign acc_a = s_axis_tvalid && rdy_a;
    assign mv_b  = r_va && rdy_b;
    assign mv_c  = r_vb && rdy_c;

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = r_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (acc_a) begin
                r_va <= 1'b1;
            end else if (mv_b) begin
                r_va <= 1'b0;
            end
            if (mv_b) begin
                r_vb <= 1'b1;
            end else if (mv_c) begin
                r_vb <= 1'b0;
            end
            if (mv_c) begin
                r_vc <= 1'b1;
            end else if (m_axis_tready) begin
                r_vc <= 1'b0;
            end
        end
    end

    // ---------------- stage A: phase accumulator ----------------
    // r_phase is both the oscillator state and the stage A payload; it only moves on a
    // transfer in, which can happen only once the previous phase has moved on.
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] inc_ext;

    assign inc_ext = PHASE_BITS'(r_phase_inc);
    assign n_phase = (s_axis_tdata[0] ? '0 : r_phase) + inc_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (acc_a) begin
            r_phase <= n_phase;
        end
    end

    // ---------------- stage B: waveform value ----------------
    logic [PHASE_BITS+31:0]      phase_wide;
    logic [31:0]                 frac;       // top 32 bits of the phase
    logic [W_BITS-1:0]           tri_mag;
    logic [SAMPLE_BITS-1:0]      saw_mag;
    logic signed [X_BITS-1:0]    tri_x;
    logic signed [X_BITS-1:0]    saw_x;
    logic signed [X_BITS-1:0]    alt_x;
    logic [TBL_BITS-1:0]         tbl_idx;
    logic [1:0]                  quad;
    logic [QTR_ADDR_BITS-1:0]    qtr_r;
    logic [QTR_ADDR_BITS-1:0]    rom_addr;
    logic [MAG_BITS-1:0]         rom_mag;

    assign phase_wide = {r_phase, 32'b0};
    assign frac       = phase_wide[PHASE_BITS+31 -: 32];
    assign tri_mag    = frac[31 -: W_BITS];
    assign saw_mag    = frac[31 -: SAMPLE_BITS];
    assign tri_x      = $signed({1'b0, tri_mag});
    assign saw_x      = $signed({2'b0, saw_mag});

    always_comb begin
        case (r_wsel)
            mwpo_pkg::WAVE_SQUARE:
                alt_x = ((r_phase != '0) && !r_phase[PHASE_BITS-1]) ? FS_X : -FS_X;
            mwpo_pkg::WAVE_TRIANGLE:
                alt_x = frac[31] ? (FS3_X - tri_x) : (tri_x - FS_X);
            mwpo_pkg::WAVE_SAW:
                alt_x = saw_x - FS_X;
            mwpo_pkg::WAVE_INV_SAW:
                alt_x = FS_X - saw_x;
            default:
                alt_x = '0;   // sine goes through the ROM; unknown codes are silent
        endcase
    end

    // quarter-wave folding: odd quadrants read the ROM mirrored, upper half negated
    assign tbl_idx  = r_phase[PHASE_BITS-1 -: TBL_BITS];
    assign quad     = tbl_idx[TBL_BITS-1 -: 2];
    assign qtr_r    = {1'b0, tbl_idx[TBL_BITS-3:0]};
    assign rom_addr = quad[0] ? (QTR_ADDR_BITS'(QTR_DEPTH) - qtr_r) : qtr_r;

    mwpo_sine_rom #(
        .ADDR_BITS (QTR_ADDR_BITS),
        .MAG_BITS  (MAG_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (mv_b),
        .i_addr (rom_addr),
        .o_mag  (rom_mag)
    );

    logic                     r_b_sine;
    logic                     r_b_neg;
    logic signed [W_BITS-1:0] r_b_alt;

    always_ff @(posedge i_clk) begin
        if (mv_b) begin
            r_b_sine <= (r_wsel == mwpo_pkg::WAVE_SINE);
            r_b_neg  <= quad[1];
            r_b_alt  <= alt_x[W_BITS-1:0];
        end
    end

    // ---------------- stage C: gain and saturation ----------------
    logic signed [W_BITS-1:0]  mag_s;
    logic signed [W_BITS-1:0]  wave_c;
    logic signed [GS_BITS-1:0] gain_s;
    logic signed [P_BITS-1:0]  prod;
    logic signed [X_BITS-1:0]  scaled;    // floor(prod / 2^16)
    logic [SAMPLE_BITS-1:0]    n_sample;
    logic [SAMPLE_BITS-1:0]    r_sample;

    assign mag_s  = $signed({2'b0, rom_mag});
    assign wave_c = r_b_sine ? (r_b_neg ? -mag_s : mag_s) : r_b_alt;
    assign gain_s = $signed({1'b0, r_gain});
    assign prod   = wave_c * gain_s;
    assign scaled = prod[P_BITS-1:mwpo_pkg::GAIN_BITS];

    always_comb begin
        if (scaled > SAT_HI) begin
            n_sample = SAT_HI[SAMPLE_BITS-1:0];
        end else if (scaled < SAT_LO) begin
            n_sample = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            n_sample = scaled[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_c) begin
            r_sample <= n_sample;
        end
    end

    assign m_axis_tdata = OUT_TDATA_BITS'(r_sample);

`ifndef SYNTH
    // restart: the phase after the tick is exactly one increment
    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_a && s_axis_tdata[0] |=> r_phase == $past(inc_ext))
        else $error("phase after restart is not one increment");

    // normal tick: phase advances by the increment, modulo one cycle
    a_advance_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_a && !s_axis_tdata[0] |=> r_phase == $past(r_phase + inc_ext))
        else $error("phase did not advance by the increment");

    // a stalled stage A keeps its phase and its item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && !rdy_b |=> r_va && $stable(r_phase))
        else $error("stage A lost its phase while stalled");

    // zero gain always gives a zero sample
    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv_c && (r_gain == '0) |=> m_axis_tdata == '0)
        else $error("nonzero sample with zero gain");
`endif

endmodule

// File: tb/multi_waveform_phase_oscillator_tb.sv
// Self-checking testbench for multi_waveform_phase_oscillator: directed, random and
// backpressure ticks. Depends on mwpo_pkg and the oscillator RTL; needs nothing else.
`timescale 1ns / 1ps

module multi_waveform_phase_oscillator_tb;

    // local copies of the sample format and the sine series constants
    localparam int          SAMPLE_W  = 16;
    localparam int          LUT_DEPTH = 1024;
    localparam longint      FS        = 32768;
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] PI_IN_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // codes the block must treat as no-ops
    localparam logic [mwpo_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic [mwpo_pkg::WAVE_BITS-1:0] WAVE_FIRST_UNKNOWN = mwpo_pkg::WAVE_INV_SAW + 3'd1;
    localparam logic [mwpo_pkg::WAVE_BITS-1:0] WAVE_LAST_UNKNOWN  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [mwpo_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [mwpo_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] restart, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample

    multi_waveform_phase_oscillator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state: its own phase, register copies and sine table
    logic [31:0]                      phase_acc;
    logic [31:0]                      phase_inc;
    logic [mwpo_pkg::GAIN_BITS-1:0]   gain;
    logic [mwpo_pkg::WAVE_BITS-1:0]   wave_sel;
    logic signed [SAMPLE_W-1:0]       sine_lut [LUT_DEPTH];

    logic [SAMPLE_W-1:0] expected_samples [$];
    logic [SAMPLE_W-1:0] want_sample;
    int                  mismatch_count = 0;

    // handshake shaping
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sine of table entry idx, scaled to full scale minus one: quarter-wave
    // folding, Q30 angle, odd series to x^11, round half up.
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx);
        logic [63:0] frac;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] theta;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] mag;
        logic [1:0]  quad;
        frac  = 64'(idx) << 22;
        quad  = frac[31:30];
        r     = frac & (Q30_ONE - 64'd1);
        u     = quad[0] ? (Q30_ONE - r) : r;
        theta = (u * PI_IN_Q30) >> 31;
        sq    = (theta * theta) >> 30;
        acc   = Q30_ONE;
        for (int k = 0; k < 5; k++) begin
            acc = Q30_ONE - (((sq * acc) >> 30) / TAYLOR_DIV[k]);
        end
        s = (theta * acc) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        mag = (s * 64'(FS - 1) + (Q30_ONE >> 1)) >> 30;
        return quad[1] ? -$signed(mag[SAMPLE_W-1:0]) : $signed(mag[SAMPLE_W-1:0]);
    endfunction

    // One tick: optional restart, phase advance, waveform, gain with floor, saturation.
    function automatic logic [SAMPLE_W-1:0] next_sample(input bit restart);
        longint level;
        longint prod;
        longint scaled;
        if (restart) begin
            phase_acc = '0;
        end
        phase_acc = phase_acc + phase_inc;
        case (wave_sel)
            mwpo_pkg::WAVE_SINE:     level = sine_lut[phase_acc[31:22]];
            mwpo_pkg::WAVE_SQUARE:   level = (phase_acc != 0 && !phase_acc[31]) ? FS : -FS;
            mwpo_pkg::WAVE_TRIANGLE: level = !phase_acc[31] ? -FS + longint'(phase_acc >> 15)
                                                            : 3 * FS - longint'(phase_acc >> 15);
            mwpo_pkg::WAVE_SAW:      level = -FS + longint'(phase_acc >> 16);
            mwpo_pkg::WAVE_INV_SAW:  level = FS - longint'(phase_acc >> 16);
            default:                 level = 0;
        endcase
        prod   = level * longint'(gain);
        scaled = prod >>> 16;
        if (scaled > FS - 1) begin
            scaled = FS - 1;
        end
        if (scaled < -FS) begin
            scaled = -FS;
        end
        return scaled[SAMPLE_W-1:0];
    endfunction

    // Output side: ready pattern set at the falling edge, long hold-offs on request.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every output transfer is matched against the oldest pending sample.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample transfer: %0d", $signed(m_axis_tdata));
                mismatch_count++;
            end else begin
                want_sample = expected_samples.pop_front();
                if (m_axis_tdata !== want_sample) begin
                    $error("sample: expected %0d, actual %0d",
                           $signed(want_sample), $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    // Entered and left at a falling edge; tvalid stays up after the transfer
    // so back-to-back ticks leave no gap in tvalid.
    task automatic send_tick(input bit restart);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, restart};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        expected_samples.push_back(next_sample(restart));
        @(negedge i_clk);
    endtask

    task automatic run_ticks(input int count, input int restart_pct);
        repeat (count) begin
            send_tick($urandom_range(99) < restart_pct);
        end
    endtask

    // Drop tvalid and let every pending sample come out before touching registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mwpo_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [mwpo_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (index)
            mwpo_pkg::CFG_PHASE_INC:   phase_inc = data;
            mwpo_pkg::CFG_VOLUME_GAIN: gain      = data[mwpo_pkg::GAIN_BITS-1:0];
            mwpo_pkg::CFG_WAVE_SELECT: wave_sel  = data[mwpo_pkg::WAVE_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] inc,
                             input logic [mwpo_pkg::GAIN_BITS-1:0] g,
                             input logic [mwpo_pkg::WAVE_BITS-1:0] wave);
        write_reg(mwpo_pkg::CFG_PHASE_INC, inc);
        write_reg(mwpo_pkg::CFG_VOLUME_GAIN, {16'h0, g});
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h0, wave});
    endtask

    // Peaks, zero crossings and the wrap point of every waveform, at full gain but for the inverse saw at half gain.
    task automatic test_waveform_extremes();
        configure(32'h4000_0000, 16'hFFFF, mwpo_pkg::WAVE_SINE);
        send_tick(1'b1);
        run_ticks(3, 0);
        wait_idle();
        configure(32'h4000_0000, 16'hFFFF, mwpo_pkg::WAVE_SQUARE);
        send_tick(1'b1);
        run_ticks(3, 0);
        wait_idle();
        // half-cycle steps hit the triangle's positive overshoot and its floor
        configure(32'h8000_0000, 16'hFFFF, mwpo_pkg::WAVE_TRIANGLE);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        configure(32'hFFFF_FFFF, 16'hFFFF, mwpo_pkg::WAVE_SAW);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        // gain written with junk above bit 15
        write_reg(mwpo_pkg::CFG_PHASE_INC, 32'h0000_0001);
        write_reg(mwpo_pkg::CFG_VOLUME_GAIN, 32'hFFFF_8000);
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h0, mwpo_pkg::WAVE_INV_SAW});
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
    endtask

    // Unknown waveforms, unknown register index, zero gain, restart mid-run.
    task automatic test_special_cases();
        write_reg(mwpo_pkg::CFG_VOLUME_GAIN, 32'h0000_FFFF);
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h1FFF_FFFF, WAVE_FIRST_UNKNOWN});
        send_tick(1'b1);
        wait_idle();
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h0, WAVE_FIRST_UNKNOWN + 3'd1});
        send_tick(1'b0);
        wait_idle();
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h0, WAVE_LAST_UNKNOWN});
        send_tick(1'b0);
        wait_idle();
        // a write to the spare index must leave every register alone
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {29'h0, mwpo_pkg::WAVE_SAW});
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        send_tick(1'b0);
        wait_idle();
        write_reg(mwpo_pkg::CFG_VOLUME_GAIN, 32'h0000_0000);
        send_tick(1'b0);
        wait_idle();
        configure(32'h1234_5678, 16'hC000, mwpo_pkg::WAVE_TRIANGLE);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
    endtask

    task automatic random_config();
        logic [31:0]                    inc;
        logic [mwpo_pkg::GAIN_BITS-1:0] g;
        logic [mwpo_pkg::WAVE_BITS-1:0] wave;
        logic [31:0]                    junk;
        logic [31:0]                    pick;
        case ($urandom_range(7))
            0:       inc = 32'h0;
            1:       inc = 32'hFFFF_FFFF;
            2:       inc = 32'h8000_0000;
            3:       inc = $urandom_range(65535, 1);
            default: inc = $urandom;
        endcase
        pick = $urandom;
        case ($urandom_range(5))
            0:       g = '0;
            1:       g = '1;
            default: g = pick[mwpo_pkg::GAIN_BITS-1:0];
        endcase
        if ($urandom_range(9) == 0) begin
            pick = $urandom_range(WAVE_LAST_UNKNOWN, WAVE_FIRST_UNKNOWN);
        end else begin
            pick = $urandom_range(mwpo_pkg::WAVE_INV_SAW, mwpo_pkg::WAVE_SINE);
        end
        wave = pick[mwpo_pkg::WAVE_BITS-1:0];
        junk = $urandom;
        write_reg(mwpo_pkg::CFG_PHASE_INC, inc);
        write_reg(mwpo_pkg::CFG_VOLUME_GAIN, {junk[31:16], g});
        write_reg(mwpo_pkg::CFG_WAVE_SELECT, {junk[28:0], wave});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, $urandom);
        end
    endtask

    // Four settings per handshake mode, about a hundred and ten ticks each mode.
    task automatic test_random_ticks(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (4) begin
            random_config();
            run_ticks(28, 10);
            wait_idle();
        end
    endtask

    // Receiver holds off long enough that the pipeline fills and input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure($urandom, 16'hFFFF, mwpo_pkg::WAVE_SAW);
        hold_cycles = 80;
        send_tick(1'b1);
        run_ticks(39, 5);
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        phase_acc     = '0;
        phase_inc     = '0;
        gain          = '0;
        wave_sel      = mwpo_pkg::WAVE_SINE;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            sine_lut[i] = sine_entry(i);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_waveform_extremes();
        test_special_cases();
        test_random_ticks(20, 69);
        test_random_ticks(69, 20);
        test_random_ticks(0, 0);
        test_backpressure();

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("multi_waveform_phase_oscillator test passed");
        end else begin
            $display("multi_waveform_phase_oscillator test failed");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("multi_waveform_phase_oscillator test failed");
        $finish;
    end

endmodule

// File: multi_waveform_phase_oscillator.f
rtl/core/mwpo_pkg.sv
rtl/core/mwpo_sine_rom.sv
rtl/core/multi_waveform_phase_oscillator.sv
tb/multi_waveform_phase_oscillator_tb.sv
